@@ rtl/jbp_pkg.sv @@
// ----------------------------------------------------------------------------
// jbp_pkg: shared types and constants of the JPEG bit packer
// Command codes, stuffing constants and the packed payload types of the
// command and byte stream channels.
// ----------------------------------------------------------------------------
package jbp_pkg;

	// command codes
	localparam logic [1:0] CMD_APPEND   = 2'd0;
	localparam logic [1:0] CMD_RAW_BYTE = 2'd1;
	localparam logic [1:0] CMD_RAW_WORD = 2'd2;
	localparam logic [1:0] CMD_ALIGN    = 2'd3;

	// fixed widths of the entropy code path
	localparam int WORD_BITS    = 16;
	localparam int MAX_CODE_LEN = 16;

	// stuffing and padding bytes
	localparam logic [7:0] STUFF_BYTE = 8'hFF;
	localparam logic [7:0] STUFF_ZERO = 8'h00;
	localparam logic [7:0] PAD_ONES   = 8'hFF;

	// command channel payload
	typedef struct packed {
		logic [1:0]  cmd;
		logic [4:0]  code_len;
		logic [15:0] code_value;
	} jbp_in_t;

	// byte stream channel payload
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} jbp_out_t;

endpackage

@@ rtl/jpeg_bit_packer_byte_stuff.sv @@
// ----------------------------------------------------------------------------
// jpeg_bit_packer_byte_stuff: JPEG entropy bit writer with byte stuffing
// Packs variable-length codes MSB first, emits whole bytes with a zero
// after each 0xFF, passes raw bytes and markers, and aligns with one bits.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-------------------------------
//   code    | in  | code_valid, code_ready | jbp_in_t  cmd, code_len, value
//   strm    | out | strm_valid, strm_ready | jbp_out_t out_byte, last_of_run
//
// The front takes one command a cycle while the two-entry queue has room.
// The back loads a byte run and then sends one byte per cycle, stuffed zeros
// included, while its output slot is free; it loads a run only when idle.
// Reset clears the accumulator, the queue's count and pointers and the output valid flag.
// A stalled byte stream fills the queue and then holds code_ready low.
// ----------------------------------------------------------------------------
module jpeg_bit_packer_byte_stuff import jbp_pkg::*; #(
	parameter int ACC_WIDTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     code_valid,
	output logic     code_ready,
	input  jbp_in_t  code_item,
	output logic     strm_valid,
	input  logic     strm_ready,
	output jbp_out_t strm_item
);

	localparam int MAX_BYTES = (ACC_WIDTH + 6) / 8;
	localparam int DATA_W    = MAX_BYTES * 8;
	localparam int NB_W      = $clog2(MAX_BYTES + 1);
	localparam int ENT_W     = DATA_W + NB_W + 1;

	logic              f_valid;
	logic              f_ready;
	logic [DATA_W-1:0] f_data;
	logic [NB_W-1:0]   f_nbytes;
	logic              f_stuff;
	logic              b_valid;
	logic              b_ready;
	logic [ENT_W-1:0]  b_ent;

	jbp_front #(
		.ACC_WIDTH (ACC_WIDTH),
		.DATA_W    (DATA_W),
		.NB_W      (NB_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code_item  (code_item),
		.q_valid    (f_valid),
		.q_ready    (f_ready),
		.q_data     (f_data),
		.q_nbytes   (f_nbytes),
		.q_stuff    (f_stuff)
	);

	jbp_fifo #(
		.WIDTH (ENT_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  ({f_stuff, f_nbytes, f_data}),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_ent)
	);

	jbp_back #(
		.DATA_W (DATA_W),
		.NB_W   (NB_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (b_valid),
		.q_ready    (b_ready),
		.q_data     (b_ent[DATA_W-1:0]),
		.q_nbytes   (b_ent[DATA_W +: NB_W]),
		.q_stuff    (b_ent[ENT_W-1]),
		.strm_valid (strm_valid),
		.strm_ready (strm_ready),
		.strm_item  (strm_item)
	);

endmodule

@@ rtl/jbp_front.sv @@
// ----------------------------------------------------------------------------
// jbp_front: command decode and bit accumulator
// Takes one command a cycle while the queue has room, updates the bit
// accumulator and hands each run of output bytes (left aligned, with count
// and stuffing flag) on to the queue.
// ----------------------------------------------------------------------------
module jbp_front import jbp_pkg::*; #(
	parameter int ACC_WIDTH = 16,
	parameter int DATA_W    = 16,
	parameter int NB_W      = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              code_valid,
	output logic              code_ready,
	input  jbp_in_t           code_item,
	output logic              q_valid,
	input  logic              q_ready,
	output logic [DATA_W-1:0] q_data,
	output logic [NB_W-1:0]   q_nbytes,
	output logic              q_stuff
);

	localparam int ACCW = ACC_WIDTH + WORD_BITS;
	localparam int CW   = $clog2(ACC_WIDTH);
	localparam int SW   = $clog2(ACCW);
	localparam int LSW  = $clog2(ACCW + 1);

	logic [ACC_WIDTH-1:0] acc_q;
	logic [CW-1:0]        cnt_q;

	logic [4:0]           len_c;
	logic [15:0]          code_mask;
	logic [3:0]           pad;
	logic [7:0]           pad_mask;
	logic [4:0]           sh;
	logic [15:0]          ins;
	logic [ACCW-1:0]      sum_acc;
	logic [SW-1:0]        sum_cnt;
	logic [LSW-1:0]       lsh;
	logic [ACCW-1:0]      left;
	logic                 emit;
	logic [CW-1:0]        keep_cnt;
	logic [ACC_WIDTH-1:0] keep_acc;
	logic [ACC_WIDTH-1:0] nxt_acc;
	logic [CW-1:0]        nxt_cnt;
	logic                 accept;

	// clamp and mask the code, work out the alignment pad
	always_comb begin
		len_c     = (code_item.code_len > 5'(MAX_CODE_LEN)) ? 5'(MAX_CODE_LEN)
			: code_item.code_len;
		code_mask = ~(16'hFFFF << len_c);
		pad       = (cnt_q[2:0] == 3'd0) ? 4'd0 : 4'd8 - {1'b0, cnt_q[2:0]};
		pad_mask  = ~(PAD_ONES << pad);
	end

	// shared insert: code bits for append, one bits for align
	always_comb begin
		if (code_item.cmd == CMD_ALIGN) begin
			sh  = {1'b0, pad};
			ins = {8'h00, pad_mask};
		end else begin
			sh  = len_c;
			ins = code_item.code_value & code_mask;
		end
		sum_acc  = (ACCW'(acc_q) << sh) | ACCW'(ins);
		sum_cnt  = SW'(cnt_q) + SW'(sh);
		lsh      = LSW'(ACCW) - LSW'(sum_cnt);
		left     = sum_acc << lsh;
		emit     = sum_cnt >= SW'(ACC_WIDTH);
		keep_cnt = emit ? CW'(sum_cnt - SW'(WORD_BITS)) : CW'(sum_cnt);
		keep_acc = sum_acc[ACC_WIDTH-1:0] & ~({ACC_WIDTH{1'b1}} << keep_cnt);
	end

	// classify the command into a byte run and the next accumulator state
	always_comb begin
		q_data   = '0;
		q_nbytes = '0;
		q_stuff  = 1'b0;
		nxt_acc  = acc_q;
		nxt_cnt  = cnt_q;
		case (code_item.cmd)
			CMD_APPEND: begin
				q_data   = left[ACCW-1 -: DATA_W];
				q_nbytes = emit ? NB_W'(2) : '0;
				q_stuff  = 1'b1;
				nxt_acc  = keep_acc;
				nxt_cnt  = keep_cnt;
			end
			CMD_RAW_BYTE: begin
				q_data[DATA_W-1 -: 8] = code_item.code_value[7:0];
				q_nbytes = NB_W'(1);
			end
			CMD_RAW_WORD: begin
				q_data[DATA_W-1 -: 16] = code_item.code_value;
				q_nbytes = NB_W'(2);
			end
			CMD_ALIGN: begin
				q_data   = left[ACCW-1 -: DATA_W];
				q_nbytes = NB_W'(sum_cnt >> 3);
				q_stuff  = 1'b1;
				nxt_acc  = '0;
				nxt_cnt  = '0;
			end
			default: begin
				q_nbytes = '0;
			end
		endcase
	end

	assign code_ready = q_ready;
	assign accept     = code_valid && code_ready;
	assign q_valid    = code_valid && (q_nbytes != '0);

	// advance the accumulator on each accepted command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			acc_q <= nxt_acc;
			cnt_q <= nxt_cnt;
		end
	end

endmodule

@@ rtl/jbp_fifo.sv @@
// ----------------------------------------------------------------------------
// jbp_fifo: two-entry queue between front and back
// Decouples command intake from byte emission so either side can stall.
// ----------------------------------------------------------------------------
module jbp_fifo import jbp_pkg::*; #(
	parameter int WIDTH = 19
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// store the entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/jbp_back.sv @@
// ----------------------------------------------------------------------------
// jbp_back: byte serializer with 0xFF stuffing
// Pops one byte run from the queue, sends its bytes most significant first,
// inserts a zero after each 0xFF of a stuffed run and marks the last byte.
// ----------------------------------------------------------------------------
module jbp_back import jbp_pkg::*; #(
	parameter int DATA_W = 16,
	parameter int NB_W   = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  logic [DATA_W-1:0] q_data,
	input  logic [NB_W-1:0]   q_nbytes,
	input  logic              q_stuff,
	output logic              strm_valid,
	input  logic              strm_ready,
	output jbp_out_t          strm_item
);

	logic              act_q;
	logic [DATA_W-1:0] data_q;
	logic [NB_W-1:0]   left_q;
	logic              stuff_en_q;
	logic              stuff_pend_q;
	logic              out_valid_q;
	jbp_out_t          out_q;

	logic              slot_free;
	logic [7:0]        cur_byte;
	logic [NB_W-1:0]   nxt_left;
	logic              nxt_pend;

	assign slot_free  = !out_valid_q || strm_ready;
	assign q_ready    = !act_q;
	assign cur_byte   = data_q[DATA_W-1 -: 8];
	assign nxt_left   = left_q - NB_W'(1);
	assign nxt_pend   = stuff_en_q && (cur_byte == STUFF_BYTE);
	assign strm_valid = out_valid_q;
	assign strm_item  = out_q;

	// load a run, then emit one byte or stuffed zero per free output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q        <= 1'b0;
			stuff_pend_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= act_q;
			end
			if (!act_q) begin
				if (q_valid) begin
					act_q        <= 1'b1;
					stuff_pend_q <= 1'b0;
				end
			end else if (slot_free) begin
				if (stuff_pend_q) begin
					stuff_pend_q <= 1'b0;
					if (left_q == '0) begin
						act_q <= 1'b0;
					end
				end else begin
					stuff_pend_q <= nxt_pend;
					if ((nxt_left == '0) && !nxt_pend) begin
						act_q <= 1'b0;
					end
				end
			end
		end
	end

	// hold run data and the output register
	always_ff @(posedge clk) begin
		if (!act_q) begin
			if (q_valid) begin
				data_q     <= q_data;
				left_q     <= q_nbytes;
				stuff_en_q <= q_stuff;
			end
		end else if (slot_free) begin
			if (stuff_pend_q) begin
				out_q.out_byte    <= STUFF_ZERO;
				out_q.last_of_run <= (left_q == '0);
			end else begin
				out_q.out_byte    <= cur_byte;
				out_q.last_of_run <= (nxt_left == '0) && !nxt_pend;
				data_q            <= data_q << 8;
				left_q            <= nxt_left;
			end
		end
	end

endmodule

@@ rtl/jbp_checker.sv @@
// ----------------------------------------------------------------------------
// jbp_checker: port-level checks of the JPEG bit packer
// Watches the top level's ports and flags output bytes without a pending
// command, output activity right after reset and stream handshake slips.
// ----------------------------------------------------------------------------
module jbp_checker import jbp_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     code_valid,
	input logic     code_ready,
	input logic     strm_valid,
	input logic     strm_ready,
	input jbp_out_t strm_item
);

	logic [31:0] open_q;
	logic        code_acc;
	logic        run_end;

	assign code_acc = code_valid && code_ready;
	assign run_end  = strm_valid && strm_ready && strm_item.last_of_run;

	// count accepted commands less the byte runs whose last byte has gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			case ({code_acc && (open_q != '1), run_end})
				2'b10:   open_q <= open_q + 32'd1;
				2'b01:   open_q <= open_q - 32'd1;
				default: open_q <= open_q;
			endcase
		end
	end

	a_byte_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		strm_valid |-> (open_q != '0))
		else $error("output byte without a pending command");

	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !strm_valid)
		else $error("output valid right after reset");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		strm_valid && !strm_ready |=> strm_valid)
		else $error("stream valid dropped before transaction");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		strm_valid && !strm_ready |=> $stable(strm_item))
		else $error("stream payload changed while stalled");

endmodule

bind jpeg_bit_packer_byte_stuff jbp_checker u_jbp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.code_valid (code_valid),
	.code_ready (code_ready),
	.strm_valid (strm_valid),
	.strm_ready (strm_ready),
	.strm_item  (strm_item)
);
